// ----- src/lhsm_pkg.sv -----
package lhsm_pkg;

  // Build-time defaults for the top-level parameters
  localparam int NUM_ENDPOINTS_DEF = 4;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int FIFO_DEPTH_DEF    = 2;

  // Fixed geometry
  localparam int NUM_BUCKETS = 8;
  localparam int BKT_W       = 3;
  localparam int EP_W        = 2;
  localparam int LAT_W       = 48;
  localparam int DL_W        = 32;
  localparam int DLNS_W      = 42;   // deadline scaled to ns
  localparam int NUM_DL      = 4;
  localparam int OUT_W       = 32;
  localparam int EST_W       = 37;
  localparam int EN_W        = 4;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REGIDX_W    = 3;

  // Register map (index = paddr / 4)
  localparam logic [REGIDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_DL0    = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_DL1    = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_DL2    = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_DL3    = 3'd4;

  // Request kinds
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Configuration seen by the front end
  typedef struct packed {
    logic [EN_W-1:0]              enable;
    logic [NUM_DL-1:0][DL_W-1:0]  deadline;
  } lhsm_cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic             query;
    logic             present;
    logic [EP_W-1:0]  ep;
    logic [BKT_W-1:0] bucket;
    logic             miss;
  } lhsm_req_t;

  // Lower edge of bucket k+1, in ns
  function automatic logic [LAT_W-1:0] bucket_edge(input logic [BKT_W-1:0] k);
    logic [LAT_W-1:0] v;
    case (k)
      3'd0:    v = 48'd100_000;
      3'd1:    v = 48'd1_000_000;
      3'd2:    v = 48'd10_000_000;
      3'd3:    v = 48'd100_000_000;
      3'd4:    v = 48'd1_000_000_000;
      3'd5:    v = 48'd10_000_000_000;
      default: v = 48'd100_000_000_000;
    endcase
    return v;
  endfunction

  // Reported floor of a bucket; the lowest bucket reports zero
  function automatic logic [EST_W-1:0] lower_edge_ns(input logic [BKT_W-1:0] b);
    logic [LAT_W-1:0] e;
    e = bucket_edge(b - 3'd1);
    return (b == '0) ? '0 : e[EST_W-1:0];
  endfunction

endpackage

// ----- src/lhsm_cfg.sv -----
module lhsm_cfg import lhsm_pkg::*; #(
  parameter int NumEndpoints = NUM_ENDPOINTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  output lhsm_cfg_t               cfg_o,
  output logic [NumEndpoints-1:0] clear_o
);

  logic [EN_W-1:0]             en_q, en_d;
  logic [NUM_DL-1:0][DL_W-1:0] dl_q, dl_d;
  logic [REGIDX_W-1:0]         idx;
  logic [EP_W-1:0]             dl_sel;
  logic                        wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign dl_sel = EP_W'(idx - REG_DL0);

  // Register writes; a newly set enable bit clears that endpoint's counters
  always_comb begin
    en_d    = en_q;
    dl_d    = dl_q;
    clear_o = '0;
    if (wr) begin
      case (idx)
        REG_ENABLE: begin
          en_d    = pwdata[EN_W-1:0];
          clear_o = pwdata[NumEndpoints-1:0] & ~en_q[NumEndpoints-1:0];
        end
        REG_DL0, REG_DL1, REG_DL2, REG_DL3: begin
          if (int'(dl_sel) < NumEndpoints) begin
            dl_d[dl_sel] = pwdata[DL_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
      dl_q <= '0;
    end else begin
      en_q <= en_d;
      dl_q <= dl_d;
    end
  end

  // Read-back
  always_comb begin
    case (idx)
      REG_ENABLE: prdata = DATA_W'(en_q);
      REG_DL0:    prdata = dl_q[0];
      REG_DL1:    prdata = dl_q[1];
      REG_DL2:    prdata = dl_q[2];
      REG_DL3:    prdata = dl_q[3];
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.enable   = en_q;
  assign cfg_o.deadline = dl_q;

endmodule

// ----- src/lhsm_front.sv -----
module lhsm_front import lhsm_pkg::*; #(
  parameter int NumEndpoints = NUM_ENDPOINTS_DEF
) (
  input  logic             start_i,
  input  logic             full_i,
  input  logic             mode_i,
  input  logic [EP_W-1:0]  endpoint_i,
  input  logic [LAT_W-1:0] latency_ns_i,
  input  lhsm_cfg_t        cfg_i,
  output logic             push_o,
  output lhsm_req_t        req_o
);

  logic              enabled;
  logic [DL_W-1:0]   dl;
  logic [DLNS_W-1:0] dl_ns;
  logic [BKT_W-1:0]  bkt;

  assign enabled = (int'(endpoint_i) < NumEndpoints) && cfg_i.enable[endpoint_i];

  // Deadline in ns: d*1000 = d*1024 - d*16 - d*8
  assign dl    = cfg_i.deadline[endpoint_i];
  assign dl_ns = (DLNS_W'(dl) << 10) - (DLNS_W'(dl) << 4) - (DLNS_W'(dl) << 3);

  // Decade bucket: lowest edge above the latency
  always_comb begin
    bkt = BKT_W'(NUM_BUCKETS - 1);
    for (int k = NUM_BUCKETS - 2; k >= 0; k--) begin
      if (latency_ns_i < bucket_edge(BKT_W'(k))) begin
        bkt = BKT_W'(k);
      end
    end
  end

  assign req_o.query   = (mode_i == MODE_QUERY);
  assign req_o.present = enabled;
  assign req_o.ep      = endpoint_i;
  assign req_o.bucket  = bkt;
  assign req_o.miss    = latency_ns_i > LAT_W'(dl_ns);

  // Records for disabled endpoints are dropped here
  assign push_o = start_i && !full_i && (req_o.query || enabled);

endmodule

// ----- src/lhsm_fifo.sv -----
module lhsm_fifo import lhsm_pkg::*; #(
  parameter int FifoDepth = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lhsm_req_t data_i,
  input  logic      pop_i,
  output lhsm_req_t data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CW = $clog2(FifoDepth + 1);

  lhsm_req_t         mem_q [FifoDepth];
  logic [AW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(FifoDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- src/lhsm_back.sv -----
module lhsm_back import lhsm_pkg::*; #(
  parameter int NumEndpoints = NUM_ENDPOINTS_DEF,
  parameter int CountBits    = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lhsm_req_t               req_i,
  input  logic                    empty_i,
  output logic                    pop_o,
  input  logic [NumEndpoints-1:0] clear_i,
  output logic                    result_valid_o,
  output logic                    present_o,
  output logic [OUT_W-1:0]        sample_count_o,
  output logic [OUT_W-1:0]        deadline_misses_o,
  output logic [EST_W-1:0]        p50_ns_o,
  output logic [EST_W-1:0]        p99_ns_o
);

  localparam int EPW = (NumEndpoints > 1) ? $clog2(NumEndpoints) : 1;
  localparam int CUW = CountBits + 3;    // running sum of eight buckets
  localparam int N9W = CountBits + 7;    // 99 * n
  localparam int HW  = CountBits + 10;   // 100 * running sum + 49

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [CountBits-1:0] cnt_q [NumEndpoints][NUM_BUCKETS];
  logic [CountBits-1:0] cnt_d [NumEndpoints][NUM_BUCKETS];
  logic [CountBits-1:0] tot_q [NumEndpoints];
  logic [CountBits-1:0] tot_d [NumEndpoints];
  logic [CountBits-1:0] mis_q [NumEndpoints];
  logic [CountBits-1:0] mis_d [NumEndpoints];

  logic                 state_q, state_d;
  logic [EPW-1:0]       qep_q, qep_d;
  logic [BKT_W-1:0]     idx_q, idx_d;
  logic [CountBits-1:0] n_q, n_d, m_q, m_d;
  logic [N9W-1:0]       n99_q, n99_d;
  logic [CUW-1:0]       cum_q, cum_d;
  logic [HW-1:0]        h_q, h_d;
  logic                 f50_q, f50_d, f99_q, f99_d;
  logic [BKT_W-1:0]     b50_q, b50_d, b99_q, b99_d;

  logic                 vld_q, vld_d;
  logic                 pres_q, pres_d;
  logic [OUT_W-1:0]     cnto_q, cnto_d, miso_q, miso_d;
  logic [EST_W-1:0]     p50_q, p50_d, p99_q, p99_d;

  logic [EPW-1:0]       rd_ep, hd_ep;
  logic [BKT_W-1:0]     rd_b;
  logic [CountBits-1:0] rd_cnt, hd_tot;
  logic [CUW-1:0]       cum_nx;
  logic [HW-1:0]        h_nx, c100;
  logic                 hit50, hit99;
  logic [BKT_W-1:0]     fin50, fin99;
  logic [CountBits+OUT_W-1:0] n_wide, m_wide;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Single read port over the bucket counters
  assign hd_ep  = req_i.ep[EPW-1:0];
  assign rd_ep  = (state_q == ST_SCAN) ? qep_q : hd_ep;
  assign rd_b   = (state_q == ST_SCAN) ? idx_q : req_i.bucket;
  assign rd_cnt = cnt_q[rd_ep][rd_b];
  assign hd_tot = tot_q[hd_ep];

  // Running sums: 2*cum >= n gives the median, 100*cum + 49 >= 99*n the p99
  assign c100   = (HW'(rd_cnt) << 6) + (HW'(rd_cnt) << 5) + (HW'(rd_cnt) << 2);
  assign cum_nx = cum_q + CUW'(rd_cnt);
  assign h_nx   = h_q + c100;
  assign hit50  = {cum_nx, 1'b0} >= (CUW + 1)'(n_q);
  assign hit99  = h_nx >= HW'(n99_q);
  assign fin50  = f50_q ? b50_q : BKT_W'(NUM_BUCKETS - 1);
  assign fin99  = f99_q ? b99_q : BKT_W'(NUM_BUCKETS - 1);

  // Clamp counts to the 32-bit result fields
  assign n_wide = {OUT_W'(0), n_q};
  assign m_wide = {OUT_W'(0), m_q};

  always_comb begin
    cnt_d   = cnt_q;
    tot_d   = tot_q;
    mis_d   = mis_q;
    state_d = state_q;
    qep_d   = qep_q;
    idx_d   = idx_q;
    n_d     = n_q;
    m_d     = m_q;
    n99_d   = n99_q;
    cum_d   = cum_q;
    h_d     = h_q;
    f50_d   = f50_q;
    f99_d   = f99_q;
    b50_d   = b50_q;
    b99_d   = b99_q;
    vld_d   = 1'b0;
    pres_d  = pres_q;
    cnto_d  = cnto_q;
    miso_d  = miso_q;
    p50_d   = p50_q;
    p99_d   = p99_q;
    pop_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (!req_i.query) begin
            // Record: bucket, total and possibly misses
            cnt_d[hd_ep][req_i.bucket] = sat_inc(rd_cnt);
            tot_d[hd_ep] = sat_inc(hd_tot);
            if (req_i.miss) begin
              mis_d[hd_ep] = sat_inc(mis_q[hd_ep]);
            end
          end else if (!req_i.present) begin
            // Query of a disabled endpoint: all-zero result
            vld_d  = 1'b1;
            pres_d = 1'b0;
            cnto_d = '0;
            miso_d = '0;
            p50_d  = '0;
            p99_d  = '0;
          end else begin
            // Query: latch totals and start the bucket walk
            state_d = ST_SCAN;
            qep_d   = hd_ep;
            idx_d   = '0;
            n_d     = hd_tot;
            m_d     = mis_q[hd_ep];
            n99_d   = (N9W'(hd_tot) << 6) + (N9W'(hd_tot) << 5)
                    + (N9W'(hd_tot) << 1) + N9W'(hd_tot);
            cum_d   = '0;
            h_d     = HW'(49);
            f50_d   = 1'b0;
            f99_d   = 1'b0;
            b50_d   = '0;
            b99_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        cum_d = cum_nx;
        h_d   = h_nx;
        if (hit50 && !f50_q) begin
          f50_d = 1'b1;
          b50_d = idx_q;
        end
        if (hit99 && !f99_q) begin
          f99_d = 1'b1;
          b99_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == BKT_W'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
          vld_d   = 1'b1;
          pres_d  = 1'b1;
          cnto_d  = (|n_wide[CountBits+OUT_W-1:OUT_W]) ? '1 : n_wide[OUT_W-1:0];
          miso_d  = (|m_wide[CountBits+OUT_W-1:OUT_W]) ? '1 : m_wide[OUT_W-1:0];
          p50_d   = (n_q == '0) ? '0 : lower_edge_ns(fin50);
          p99_d   = (n_q == '0) ? '0 : lower_edge_ns(fin99);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Registration clears an endpoint's counters
    for (int e = 0; e < NumEndpoints; e++) begin
      if (clear_i[e]) begin
        for (int b = 0; b < NUM_BUCKETS; b++) begin
          cnt_d[e][b] = '0;
        end
        tot_d[e] = '0;
        mis_d[e] = '0;
      end
    end
  end

  // Counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NumEndpoints; e++) begin
        for (int b = 0; b < NUM_BUCKETS; b++) begin
          cnt_q[e][b] <= '0;
        end
        tot_q[e] <= '0;
        mis_q[e] <= '0;
      end
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      mis_q   <= mis_d;
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  // Query working registers and result payload
  always_ff @(posedge clk_i) begin
    qep_q  <= qep_d;
    idx_q  <= idx_d;
    n_q    <= n_d;
    m_q    <= m_d;
    n99_q  <= n99_d;
    cum_q  <= cum_d;
    h_q    <= h_d;
    f50_q  <= f50_d;
    f99_q  <= f99_d;
    b50_q  <= b50_d;
    b99_q  <= b99_d;
    pres_q <= pres_d;
    cnto_q <= cnto_d;
    miso_q <= miso_d;
    p50_q  <= p50_d;
    p99_q  <= p99_d;
  end

  assign result_valid_o    = vld_q;
  assign present_o         = pres_q;
  assign sample_count_o    = cnto_q;
  assign deadline_misses_o = miso_q;
  assign p50_ns_o          = p50_q;
  assign p99_ns_o          = p99_q;

endmodule

// ----- src/latency_histogram_sla_monitor_top.sv -----
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+---------------------------------------
// request   | start, busy (taken: start & !busy)| mode_i, endpoint_i, latency_ns_i
// result    | result_valid_o, one-cycle strobe | present_o, sample_count_o,
//           |                                  | deadline_misses_o, p50_ns_o, p99_ns_o
// config    | APB psel/penable/pwrite, pready=1| paddr (reg * 4), pwdata, prdata
//
// Records update the counters from idle and stream at one per cycle between queries.
// A query walks the endpoint's eight bucket counters through the single counter read
// port; the result is strobed on the cycle after the last bucket is read.
// A two-entry request queue sits between classification and the engine; busy is the
// queue being full, which only happens behind a query. Results cannot be stalled.
// rst_ni clears all counters, enables and deadlines asynchronously.
module latency_histogram_sla_monitor_top import lhsm_pkg::*; #(
  parameter int NumEndpoints = NUM_ENDPOINTS_DEF,
  parameter int CountBits    = COUNT_BITS_DEF,
  parameter int FifoDepth    = FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request
  input  logic              start,
  output logic              busy,
  input  logic              mode_i,
  input  logic [EP_W-1:0]   endpoint_i,
  input  logic [LAT_W-1:0]  latency_ns_i,
  // result
  output logic              result_valid_o,
  output logic              present_o,
  output logic [OUT_W-1:0]  sample_count_o,
  output logic [OUT_W-1:0]  deadline_misses_o,
  output logic [EST_W-1:0]  p50_ns_o,
  output logic [EST_W-1:0]  p99_ns_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  lhsm_cfg_t               cfg;
  logic [NumEndpoints-1:0] clear;
  lhsm_req_t               req_in, req_hd;
  logic                    push, pop, empty, full;

  assign busy = full;

  // Register block
  lhsm_cfg #(
    .NumEndpoints (NumEndpoints)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  // Classification
  lhsm_front #(
    .NumEndpoints (NumEndpoints)
  ) u_front (
    .start_i      (start),
    .full_i       (full),
    .mode_i       (mode_i),
    .endpoint_i   (endpoint_i),
    .latency_ns_i (latency_ns_i),
    .cfg_i        (cfg),
    .push_o       (push),
    .req_o        (req_in)
  );

  // Request queue
  lhsm_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (req_in),
    .pop_i   (pop),
    .data_o  (req_hd),
    .empty_o (empty),
    .full_o  (full)
  );

  // Counter engine
  lhsm_back #(
    .NumEndpoints (NumEndpoints),
    .CountBits    (CountBits)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req_hd),
    .empty_i           (empty),
    .pop_o             (pop),
    .clear_i           (clear),
    .result_valid_o    (result_valid_o),
    .present_o         (present_o),
    .sample_count_o    (sample_count_o),
    .deadline_misses_o (deadline_misses_o),
    .p50_ns_o          (p50_ns_o),
    .p99_ns_o          (p99_ns_o)
  );

endmodule
